### sv/mda_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mda_pkg
// Types, constants and helpers shared by the distance approximation block.
// ---------------------------------------------------------------------------
package mda_pkg;

    localparam int COORD_BITS = 32;
    localparam int RAD_W      = 74;
    localparam int ROOT_W     = 37;
    localparam int SQREM_W    = 39;
    localparam int DEN_W      = 33;
    localparam int DEN8_W     = 41;
    localparam int NUM_W      = 73;
    localparam int Q_W        = 40;
    localparam int CIRC_W     = 36;

    localparam logic [31:0] DIST_COEF0_RST  = 32'd16777216;
    localparam logic [31:0] DIST_COEF2_RST  = 32'd325977162;
    localparam logic [31:0] DIST_COEF4_RST  = 32'd1245258622;
    localparam logic [31:0] YCORR_COEF0_RST = 32'd266638447;
    localparam logic [31:0] YCORR_COEF2_RST = 32'd50098407;
    localparam logic [31:0] YCORR_COEF4_RST = 32'hE8B7_E34E;
    localparam logic [CIRC_W-1:0] CIRC_RST  = 36'd40075016686;

    typedef enum logic [2:0] {
        REG_DIST_COEF0  = 3'd0,
        REG_DIST_COEF2  = 3'd1,
        REG_DIST_COEF4  = 3'd2,
        REG_YCORR_COEF0 = 3'd3,
        REG_YCORR_COEF2 = 3'd4,
        REG_YCORR_COEF4 = 3'd5,
        REG_CIRC        = 3'd6,
        REG_SPARE       = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
    } in_word_t;

    typedef struct packed {
        logic [Q_W-1:0] distance_mm;
        logic           saturated;
    } out_word_t;

    typedef struct packed {
        logic [31:0] dist_coef0;
        logic [31:0] dist_coef2;
        logic [31:0] dist_coef4;
        logic [31:0] ycorr_coef0;
        logic [31:0] ycorr_coef2;
        logic [31:0] ycorr_coef4;
    } coef_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [DEN_W-1:0] den;
    } front_t;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [ROOT_W-1:0]  root;
        logic [SQREM_W-1:0] rem;
        logic [DEN_W-1:0]   den;
    } sq_t;

    typedef struct packed {
        logic [DEN8_W-1:0] rem;
        logic [Q_W-1:0]    num;
        logic [Q_W-1:0]    q;
        logic [DEN8_W-1:0] den8;
        logic              sat;
    } dv_t;

    function automatic logic [31:0] align_coord(input logic [COORD_BITS-1:0] v);
        logic [COORD_BITS+31:0] w;
        w = {v, 32'd0} >> COORD_BITS;
        return w[31:0];
    endfunction

    function automatic logic [31:0] coef_mag(input logic [31:0] raw);
        return raw[31] ? (32'd0 - raw) : raw;
    endfunction

    function automatic logic signed [33:0] apply_sign(input logic [31:0] mag,
                                                      input logic neg);
        logic signed [33:0] m;
        m = signed'({2'b00, mag});
        return neg ? -m : m;
    endfunction

endpackage

### sv/mda_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mda_front
// Eight-stage front end: deltas, z powers, both quartics, squared radicand.
// ---------------------------------------------------------------------------
module mda_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mda_pkg::in_word_t   in_word,
    input  mda_pkg::coef_t      coef,
    output logic                out_valid,
    output mda_pkg::front_t     out_data
);

    localparam int DEN_W_L = mda_pkg::DEN_W;

    logic [7:0] valid_reg;

    logic [31:0] x1, y1, x2, y2;
    logic [32:0] ysum, zs;
    logic [31:0] s1_adx_reg, s1_ady_reg, s1_za_reg;
    logic [31:0] s1_adx_next, s1_ady_next;

    logic [63:0] p2;
    logic [31:0] s2_adx_reg, s2_ady_reg, s2_z2_reg;

    logic [63:0] p3_z4, p3_d2, p3_y2;
    logic [31:0] s3_adx_reg, s3_ady_reg, s3_z4_reg, s3_dt2_reg, s3_yt2_reg;

    logic [63:0] p4_d4, p4_y4;
    logic [31:0] s4_adx_reg, s4_ady_reg, s4_dt2_reg, s4_yt2_reg;
    logic [31:0] s4_dt4_reg, s4_yt4_reg;

    logic [DEN_W_L-1:0] s5_den_next;
    logic signed [33:0] sc;
    logic [33:0]        sc_abs;
    logic [31:0] s5_adx_reg, s5_ady_reg, s5_sabs_reg;
    logic [32:0] s5_den_reg;

    logic [63:0] p6_dy, p6_dx;
    logic [35:0] s6_dyc_reg;
    logic [63:0] s6_dx2_reg;
    logic [32:0] s6_den_reg;

    logic [63:0] s7_dx2_reg;
    logic [71:0] s7_dy2_reg;
    logic [32:0] s7_den_reg;

    logic [mda_pkg::RAD_W-1:0] s8_rad_reg;
    logic [32:0]               s8_den_reg;

    always_comb
    begin
        x1 = mda_pkg::align_coord(in_word.first_x);
        y1 = mda_pkg::align_coord(in_word.first_y);
        x2 = mda_pkg::align_coord(in_word.second_x);
        y2 = mda_pkg::align_coord(in_word.second_y);
        s1_adx_next = (x1 >= x2) ? (x1 - x2) : (x2 - x1);
        s1_ady_next = (y1 >= y2) ? (y1 - y2) : (y2 - y1);
        ysum = {1'b0, y1} + {1'b0, y2};
        zs   = ysum[32] ? {1'b0, ysum[31:0]} : (33'h1_0000_0000 - ysum);
    end

    assign p2    = 64'(s1_za_reg) * 64'(s1_za_reg);
    assign p3_z4 = 64'(s2_z2_reg) * 64'(s2_z2_reg);
    assign p3_d2 = 64'(coef.dist_coef2) * 64'(s2_z2_reg);
    assign p3_y2 = 64'(mda_pkg::coef_mag(coef.ycorr_coef2)) * 64'(s2_z2_reg);
    assign p4_d4 = 64'(coef.dist_coef4) * 64'(s3_z4_reg);
    assign p4_y4 = 64'(mda_pkg::coef_mag(coef.ycorr_coef4)) * 64'(s3_z4_reg);

    always_comb
    begin
        s5_den_next = 33'(coef.dist_coef0) + 33'(s4_dt2_reg) + 33'(s4_dt4_reg);
        sc = mda_pkg::apply_sign(mda_pkg::coef_mag(coef.ycorr_coef0), coef.ycorr_coef0[31])
           + mda_pkg::apply_sign(s4_yt2_reg, coef.ycorr_coef2[31])
           + mda_pkg::apply_sign(s4_yt4_reg, coef.ycorr_coef4[31]);
        sc_abs = sc[33] ? unsigned'(-sc) : unsigned'(sc);
    end

    assign p6_dy = 64'(s5_ady_reg) * 64'(s5_sabs_reg);
    assign p6_dx = 64'(s5_adx_reg) * 64'(s5_adx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_adx_reg  <= s1_adx_next;
            s1_ady_reg  <= s1_ady_next;
            s1_za_reg   <= zs[32:1];

            s2_adx_reg  <= s1_adx_reg;
            s2_ady_reg  <= s1_ady_reg;
            s2_z2_reg   <= p2[63:32];

            s3_adx_reg  <= s2_adx_reg;
            s3_ady_reg  <= s2_ady_reg;
            s3_z4_reg   <= p3_z4[63:32];
            s3_dt2_reg  <= p3_d2[63:32];
            s3_yt2_reg  <= p3_y2[63:32];

            s4_adx_reg  <= s3_adx_reg;
            s4_ady_reg  <= s3_ady_reg;
            s4_dt2_reg  <= s3_dt2_reg;
            s4_yt2_reg  <= s3_yt2_reg;
            s4_dt4_reg  <= p4_d4[63:32];
            s4_yt4_reg  <= p4_y4[63:32];

            s5_adx_reg  <= s4_adx_reg;
            s5_ady_reg  <= s4_ady_reg;
            s5_den_reg  <= s5_den_next;
            s5_sabs_reg <= sc_abs[31:0];

            s6_dyc_reg  <= p6_dy[63:28];
            s6_dx2_reg  <= p6_dx;
            s6_den_reg  <= s5_den_reg;

            s7_dx2_reg  <= s6_dx2_reg;
            s7_dy2_reg  <= 72'(s6_dyc_reg) * 72'(s6_dyc_reg);
            s7_den_reg  <= s6_den_reg;

            s8_rad_reg  <= 74'(s7_dx2_reg) + 74'(s7_dy2_reg);
            s8_den_reg  <= s7_den_reg;
        end
    end

    assign out_valid     = valid_reg[7];
    assign out_data.rad  = s8_rad_reg;
    assign out_data.den  = s8_den_reg;

endmodule

### sv/mda_sqrt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mda_sqrt_cell
// One root bit: bring in two radicand bits, trial subtract, pass right.
// ---------------------------------------------------------------------------
module mda_sqrt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  mda_pkg::sq_t  in_data,
    output logic          out_valid,
    output mda_pkg::sq_t  out_data
);

    logic                         valid_reg;
    mda_pkg::sq_t                 data_reg;
    mda_pkg::sq_t                 data_next;
    logic [mda_pkg::SQREM_W-1:0]  rem2;
    logic [mda_pkg::SQREM_W-1:0]  trial;

    always_comb
    begin
        rem2  = {in_data.rem[mda_pkg::SQREM_W-3:0],
                 in_data.rad[mda_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, in_data.root[mda_pkg::SQREM_W-4:0], 2'b01};
        data_next     = in_data;
        data_next.rad = {in_data.rad[mda_pkg::RAD_W-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            data_next.rem  = rem2 - trial;
            data_next.root = {in_data.root[mda_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem2;
            data_next.root = {in_data.root[mda_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/mda_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mda_div_cell
// One quotient bit of a restoring division, handed to the next cell.
// ---------------------------------------------------------------------------
module mda_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  mda_pkg::dv_t  in_data,
    output logic          out_valid,
    output mda_pkg::dv_t  out_data
);

    logic                       valid_reg;
    mda_pkg::dv_t               data_reg;
    mda_pkg::dv_t               data_next;
    logic [mda_pkg::DEN8_W:0]   rem2;

    always_comb
    begin
        rem2 = {in_data.rem, in_data.num[mda_pkg::Q_W-1]};
        data_next     = in_data;
        data_next.num = {in_data.num[mda_pkg::Q_W-2:0], 1'b0};
        if (rem2 >= {1'b0, in_data.den8})
        begin
            data_next.rem = mda_pkg::DEN8_W'(rem2 - {1'b0, in_data.den8});
            data_next.q   = {in_data.q[mda_pkg::Q_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = rem2[mda_pkg::DEN8_W-1:0];
            data_next.q   = {in_data.q[mda_pkg::Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/mercator_distance_approx.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mercator_distance_approx
// Approximate ground distance between two web-mercator points.
// ---------------------------------------------------------------------------
// One coordinate pair enters every cycle while the output is not stalled;
// each word passes through 8 front-end stages, 37 square-root cells, 2
// scaling stages, 40 divider cells and the output register. The whole
// pipeline holds while the output word is stalled; coefficient writes are
// taken in any cycle and must be made while no word is in flight.
module mercator_distance_approx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  mda_pkg::in_word_t    src_word,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output mda_pkg::out_word_t   dst_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [35:0]          cfg_data
);

    localparam int SQ_N = mda_pkg::ROOT_W;
    localparam int DV_N = mda_pkg::Q_W;

    logic                  en;
    mda_pkg::coef_t        coef_reg;
    logic [35:0]           circ_reg;

    logic                  fr_valid;
    mda_pkg::front_t       fr_data;

    logic                  sq_valid [0:SQ_N];
    mda_pkg::sq_t          sq_data  [0:SQ_N];
    logic                  dv_valid [0:DV_N];
    mda_pkg::dv_t          dv_data  [0:DV_N];

    logic                          sc1_valid_reg, sc2_valid_reg;
    logic [mda_pkg::NUM_W-1:0]     sc1_num_reg;
    logic [mda_pkg::DEN_W-1:0]     sc1_den_reg;
    mda_pkg::dv_t                  sc2_data_reg;
    mda_pkg::dv_t                  sc2_data_next;

    logic                  dst_valid_reg;
    mda_pkg::out_word_t    dst_word_reg;

    assign en        = !dst_valid_reg || !dst_stall;
    assign src_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.dist_coef0  <= mda_pkg::DIST_COEF0_RST;
            coef_reg.dist_coef2  <= mda_pkg::DIST_COEF2_RST;
            coef_reg.dist_coef4  <= mda_pkg::DIST_COEF4_RST;
            coef_reg.ycorr_coef0 <= mda_pkg::YCORR_COEF0_RST;
            coef_reg.ycorr_coef2 <= mda_pkg::YCORR_COEF2_RST;
            coef_reg.ycorr_coef4 <= mda_pkg::YCORR_COEF4_RST;
            circ_reg             <= mda_pkg::CIRC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mda_pkg::cfg_reg_t'(cfg_index))
                mda_pkg::REG_DIST_COEF0:  coef_reg.dist_coef0  <= cfg_data[31:0];
                mda_pkg::REG_DIST_COEF2:  coef_reg.dist_coef2  <= cfg_data[31:0];
                mda_pkg::REG_DIST_COEF4:  coef_reg.dist_coef4  <= cfg_data[31:0];
                mda_pkg::REG_YCORR_COEF0: coef_reg.ycorr_coef0 <= cfg_data[31:0];
                mda_pkg::REG_YCORR_COEF2: coef_reg.ycorr_coef2 <= cfg_data[31:0];
                mda_pkg::REG_YCORR_COEF4: coef_reg.ycorr_coef4 <= cfg_data[31:0];
                mda_pkg::REG_CIRC:        circ_reg             <= cfg_data;
                default:                  ;
            endcase
        end
    end

    mda_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (src_valid),
        .in_word  (src_word),
        .coef     (coef_reg),
        .out_valid(fr_valid),
        .out_data (fr_data)
    );

    assign sq_valid[0]     = fr_valid;
    assign sq_data[0].rad  = fr_data.rad;
    assign sq_data[0].root = '0;
    assign sq_data[0].rem  = '0;
    assign sq_data[0].den  = fr_data.den;

    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        mda_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (sq_valid[i]),
            .in_data  (sq_data[i]),
            .out_valid(sq_valid[i+1]),
            .out_data (sq_data[i+1])
        );
    end

    always_comb
    begin
        sc2_data_next.den8 = {sc1_den_reg, 8'd0};
        sc2_data_next.rem  = mda_pkg::DEN8_W'(sc1_num_reg[mda_pkg::NUM_W-1:mda_pkg::Q_W]);
        sc2_data_next.num  = sc1_num_reg[mda_pkg::Q_W-1:0];
        sc2_data_next.q    = '0;
        sc2_data_next.sat  = (sc1_den_reg == '0)
            || (mda_pkg::DEN8_W'(sc1_num_reg[mda_pkg::NUM_W-1:mda_pkg::Q_W])
                >= {sc1_den_reg, 8'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc1_valid_reg <= 1'b0;
            sc2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sc1_valid_reg <= sq_valid[SQ_N];
            sc2_valid_reg <= sc1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc1_num_reg  <= mda_pkg::NUM_W'(sq_data[SQ_N].root)
                          * mda_pkg::NUM_W'(circ_reg);
            sc1_den_reg  <= sq_data[SQ_N].den;
            sc2_data_reg <= sc2_data_next;
        end
    end

    assign dv_valid[0] = sc2_valid_reg;
    assign dv_data[0]  = sc2_data_reg;

    for (genvar j = 0; j < DV_N; j++)
    begin : g_div
        mda_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (dv_valid[j]),
            .in_data  (dv_data[j]),
            .out_valid(dv_valid[j+1]),
            .out_data (dv_data[j+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dst_valid_reg <= dv_valid[DV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dst_word_reg.saturated   <= dv_data[DV_N].sat;
            dst_word_reg.distance_mm <= dv_data[DV_N].sat ? '1 : dv_data[DV_N].q;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_word.saturated |-> dst_word.distance_mm == '1)
        else $error("saturated word without full-scale distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        src_stall == (dst_valid && dst_stall))
        else $error("input stall out of step with output stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        en && dv_valid[DV_N] |=> dst_valid)
        else $error("divider word lost before output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sq_valid[SQ_N]) && $stable(dv_valid[DV_N]))
        else $error("pipeline moved while held");
`endif

endmodule

### sim/mda_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mda_checker
// Watches the coordinate, distance and coefficient channels of the distance
// block. Keeps a shadow copy of the coefficient registers, predicts each
// distance word in fixed point and compares it with the word that leaves.
// ---------------------------------------------------------------------------
module mda_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_stall,
    input  mda_pkg::in_word_t   src_word,
    input  logic                dst_valid,
    input  logic                dst_stall,
    input  mda_pkg::out_word_t  dst_word,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [35:0]         cfg_data,
    output int                  fail_count,
    output int                  words_pending,
    output int                  words_checked,
    output int                  words_saturated
);

    logic [31:0]                dcoef [3];
    logic [31:0]                ycoef [3];
    logic [mda_pkg::CIRC_W-1:0] circ_mm;
    mda_pkg::out_word_t         distance_queue [$];

    function automatic logic signed [63:0] corr_term(input logic [31:0] raw,
                                                     input logic [63:0] zp);
        logic [63:0] mag;
        logic [63:0] p;
        mag = raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
        p = (mag * zp) >> 32;
        return raw[31] ? -$signed(p) : $signed(p);
    endfunction

    function automatic mda_pkg::out_word_t predict_distance(input mda_pkg::in_word_t w);
        logic [31:0]        adx;
        logic [31:0]        ady;
        logic [32:0]        ysum;
        logic [32:0]        zabs;
        logic [63:0]        z2;
        logic [63:0]        z4;
        logic [63:0]        den;
        logic signed [63:0] corr;
        logic [63:0]        cabs;
        logic [63:0]        dyc;
        logic [127:0]       rad;
        logic [127:0]       root;
        logic [127:0]       trial;
        logic [127:0]       quo;
        mda_pkg::out_word_t r;
        adx = (w.first_x >= w.second_x) ? w.first_x - w.second_x : w.second_x - w.first_x;
        ady = (w.first_y >= w.second_y) ? w.first_y - w.second_y : w.second_y - w.first_y;
        ysum = {1'b0, w.first_y} + {1'b0, w.second_y};
        zabs = ysum[32] ? (ysum - 33'h1_0000_0000) : (33'h1_0000_0000 - ysum);
        zabs = zabs >> 1;
        z2 = (64'(zabs) * 64'(zabs)) >> 32;
        z4 = (z2 * z2) >> 32;
        den = 64'(dcoef[0]) + ((64'(dcoef[1]) * z2) >> 32)
            + ((64'(dcoef[2]) * z4) >> 32);
        corr = corr_term(ycoef[0], 64'h1_0000_0000) + corr_term(ycoef[1], z2)
             + corr_term(ycoef[2], z4);
        cabs = (corr < 0) ? 64'(-corr) : 64'(corr);
        dyc = 64'(ady) * (cabs >> 28) + ((64'(ady) * (cabs & 64'hFFF_FFFF)) >> 28);
        rad = 128'(adx) * 128'(adx) + 128'(dyc) * 128'(dyc);
        root = '0;
        for (int b = 39; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= rad)
                root = trial;
        end
        if (den == 0)
        begin
            r.distance_mm = '1;
            r.saturated   = 1'b1;
        end
        else
        begin
            quo = (root * 128'(circ_mm)) / (128'(den) << 8);
            if (quo >= (128'd1 << mda_pkg::Q_W))
            begin
                r.distance_mm = '1;
                r.saturated   = 1'b1;
            end
            else
            begin
                r.distance_mm = quo[mda_pkg::Q_W-1:0];
                r.saturated   = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mda_pkg::out_word_t exp_w;
        if (!rst_n)
        begin
            dcoef[0] <= mda_pkg::DIST_COEF0_RST;
            dcoef[1] <= mda_pkg::DIST_COEF2_RST;
            dcoef[2] <= mda_pkg::DIST_COEF4_RST;
            ycoef[0] <= mda_pkg::YCORR_COEF0_RST;
            ycoef[1] <= mda_pkg::YCORR_COEF2_RST;
            ycoef[2] <= mda_pkg::YCORR_COEF4_RST;
            circ_mm  <= mda_pkg::CIRC_RST;
            distance_queue.delete();
            fail_count      <= 0;
            words_pending   <= 0;
            words_checked   <= 0;
            words_saturated <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (mda_pkg::cfg_reg_t'(cfg_index))
                    mda_pkg::REG_DIST_COEF0:  dcoef[0] <= cfg_data[31:0];
                    mda_pkg::REG_DIST_COEF2:  dcoef[1] <= cfg_data[31:0];
                    mda_pkg::REG_DIST_COEF4:  dcoef[2] <= cfg_data[31:0];
                    mda_pkg::REG_YCORR_COEF0: ycoef[0] <= cfg_data[31:0];
                    mda_pkg::REG_YCORR_COEF2: ycoef[1] <= cfg_data[31:0];
                    mda_pkg::REG_YCORR_COEF4: ycoef[2] <= cfg_data[31:0];
                    mda_pkg::REG_CIRC:        circ_mm  <= cfg_data;
                    default: ;
                endcase
            end
            if (src_valid && !src_stall)
                distance_queue.push_back(predict_distance(src_word));
            if (dst_valid && !dst_stall)
            begin
                if (distance_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected word %h", dst_word);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = distance_queue.pop_front();
                    words_checked <= words_checked + 1;
                    if (exp_w.saturated)
                        words_saturated <= words_saturated + 1;
                    if (exp_w.distance_mm !== dst_word.distance_mm
                        || exp_w.saturated !== dst_word.saturated)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: distance exp %0d/%0b got %0d/%0b",
                                     exp_w.distance_mm, exp_w.saturated,
                                     dst_word.distance_mm, dst_word.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            words_pending <= distance_queue.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives coordinate pairs and coefficient writes into the distance block
// under random gaps and stalls, including one long output hold, across
// several coefficient settings; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    mda_pkg::in_word_t  src_word = '0;
    logic               dst_valid;
    logic               dst_stall = 1'b0;
    mda_pkg::out_word_t dst_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [35:0]        cfg_data = '0;

    int fail_count;
    int words_pending;
    int words_checked;
    int words_saturated;
    int words_sent = 0;
    int settings_run = 0;
    bit rx_busy_only = 1'b0;
    bit tx_busy_only = 1'b0;
    bit hold_req = 1'b0;

    mercator_distance_approx u_dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall), .src_word(src_word),
        .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_word(dst_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mda_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall), .src_word(src_word),
        .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_word(dst_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .words_pending(words_pending),
        .words_checked(words_checked), .words_saturated(words_saturated)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("FAILURE");
        $finish;
    end

    // output side: random stalls, one long hold on request
    initial
    begin
        int k;
        bit took;
        @(posedge rst_n);
        forever
        begin
            k = rx_busy_only ? 0 : $urandom_range(0, 5);
            if (hold_req)
            begin
                k = 400;
                hold_req = 1'b0;
            end
            if (k > 0)
            begin
                dst_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            dst_stall <= 1'b0;
            took = 1'b0;
            while (!took)
            begin
                @(negedge clk);
                took = dst_valid;
                @(posedge clk);
            end
        end
    end

    task automatic send_word(input mda_pkg::in_word_t w);
        int gap;
        bit took;
        gap = tx_busy_only ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !src_stall;
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic write_reg(input mda_pkg::cfg_reg_t idx, input logic [35:0] value);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_coefs(input logic [31:0] d0, input logic [31:0] d2,
                              input logic [31:0] d4, input logic [31:0] y0,
                              input logic [31:0] y2, input logic [31:0] y4,
                              input logic [35:0] circ);
        write_reg(mda_pkg::REG_DIST_COEF0, {4'($urandom_range(0, 15)), d0});
        write_reg(mda_pkg::REG_DIST_COEF2, {4'h0, d2});
        write_reg(mda_pkg::REG_DIST_COEF4, {4'hF, d4});
        write_reg(mda_pkg::REG_YCORR_COEF0, {4'h0, y0});
        write_reg(mda_pkg::REG_YCORR_COEF2, {4'h0, y2});
        write_reg(mda_pkg::REG_YCORR_COEF4, {4'h0, y4});
        write_reg(mda_pkg::REG_CIRC, circ);
        settings_run++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] near_coord(input logic [31:0] c);
        logic [31:0] d;
        d = $urandom >> $urandom_range(4, 31);
        return $urandom_range(0, 1) ? c + d : c - d;
    endfunction

    task automatic random_words(input int n);
        mda_pkg::in_word_t w;
        repeat (n)
        begin
            w.first_x = rand_coord();
            w.first_y = rand_coord();
            if ($urandom_range(0, 2) != 0)
            begin
                w.second_x = near_coord(w.first_x);
                w.second_y = near_coord(w.first_y);
            end
            else
            begin
                w.second_x = rand_coord();
                w.second_y = rand_coord();
            end
            send_word(w);
        end
    endtask

    task automatic directed_words();
        logic [31:0] y;
        send_word('0);
        send_word('1);
        send_word({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0});
        send_word({32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0});
        send_word({32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
        send_word({32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF});
        send_word({32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000});
        send_word({32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF});
        send_word({32'h1234_5678, 32'h4000_0000, 32'h1234_5679, 32'hC000_0000});
        y = $urandom;
        send_word({32'h0, y, 32'h1000, 32'd0 - y});
        send_word({32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA});
        send_word({32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        random_words(60);
        hold_req = 1'b1;
        tx_busy_only = 1'b1;
        random_words(200);
        tx_busy_only = 1'b0;
        rx_busy_only = 1'b1;
        random_words(80);
        rx_busy_only = 1'b0;
        drain();

        load_coefs('1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
        directed_words();
        random_words(120);
        drain();

        load_coefs('0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
        directed_words();
        random_words(60);
        drain();

        load_coefs(32'd1, '0, '0, 32'h8000_0000, '0, 32'h7FFF_FFFF, '1);
        directed_words();
        random_words(80);
        drain();

        load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   {4'($urandom_range(0, 15)), $urandom});
        write_reg(mda_pkg::REG_SPARE, {4'hF, $urandom});
        random_words(120);
        drain();

        load_coefs(mda_pkg::DIST_COEF0_RST, mda_pkg::DIST_COEF2_RST,
                   mda_pkg::DIST_COEF4_RST, mda_pkg::YCORR_COEF0_RST,
                   mda_pkg::YCORR_COEF2_RST, mda_pkg::YCORR_COEF4_RST,
                   mda_pkg::CIRC_RST);
        random_words(200);
        drain();

        $display("Run covered %0d coordinate pairs over %0d coefficient loads,",
                 words_sent, settings_run);
        $display("%0d distances compared, %0d of them saturated.",
                 words_checked, words_saturated);
        if (fail_count == 0 && words_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
